// File: src/u2a_pkg.sv
package u2a_pkg;

  // Status codes carried on the final word of a string.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_UNMAPPABLE = 2'd2;

  // Special ROM codes: unmapped pair, pair that maps to nothing, and digraphs.
  localparam logic [7:0] RC_NONE  = 8'h00;
  localparam logic [7:0] RC_EMPTY = 8'h2D;  // '-'
  localparam logic [7:0] RC_UNMAP = 8'h2E;  // '.'
  localparam logic [7:0] RC_AE    = 8'h31;  // '1'
  localparam logic [7:0] RC_TH    = 8'h32;  // '2'
  localparam logic [7:0] RC_SS    = 8'h33;  // '3'
  localparam logic [7:0] RC_OE    = 8'h34;  // '4'

  // Fold tables for leads C3 to C6, first character in the top byte.
  localparam logic [8*64-1:0] ROM_C3 =
    "aaaaaa1ceeeeiiiidnooooo.ouuuuy23aaaaaa1ceeeeiiiidnooooo.ouuuuy2y";
  localparam logic [8*64-1:0] ROM_C4 =
    "aaaaaaccccccccddddeeeeeeeeeegggggggghhhhiiiiiiiiiijjkkkklllllll.";
  localparam logic [8*64-1:0] ROM_C5 =
    ".llnnnnnn...oooooo44rrrrrrssssssssttttuuuuuuuuuuuuwwyyyyyzzzzzz.";
  localparam logic [8*16-1:0] ROM_C6 = "bbbbccdddeffgghi";

  // One result word.
  typedef struct packed {
    logic [6:0] letter;
    logic       has_letter;
    logic       string_done;
    logic [1:0] status;
  } u2a_res_t;

  // Sequence state kept between bytes.
  typedef struct packed {
    logic [1:0] bytes_pending;
    logic [7:0] lead_byte;
    logic [2:0] seq_length;
    logic [1:0] error_code;
  } u2a_state_t;

  // Looks up a two-byte pair. Returns RC_NONE when the pair is not mapped.
  function automatic logic [7:0] rom_lookup(input logic [7:0] lead,
                                            input logic [7:0] second);
    logic [5:0] idx;
    logic [7:0] c;
    idx = second[5:0];
    c   = RC_NONE;
    if (second[7:6] == 2'b10) begin
      case (lead)
        8'hC3: c = ROM_C3[{~idx, 3'b000} +: 8];
        8'hC4: c = ROM_C4[{~idx, 3'b000} +: 8];
        8'hC5: c = ROM_C5[{~idx, 3'b000} +: 8];
        8'hC6: c = (idx[5:4] == 2'b00) ? ROM_C6[{~idx[3:0], 3'b000} +: 8] : RC_NONE;
        8'hC8: begin
          if (idx == 6'h18 || idx == 6'h19) begin
            c = 8'h73;
          end else if (idx == 6'h1A || idx == 6'h1B) begin
            c = 8'h74;
          end else begin
            c = RC_NONE;
          end
        end
        8'hCC: c = (idx[5] == 1'b0) ? RC_EMPTY : RC_NONE;
        default: c = RC_NONE;
      endcase
      if (c == RC_UNMAP) begin
        c = RC_NONE;
      end
    end
    return c;
  endfunction

endpackage

// File: src/utf8_to_ascii_letter_folder.sv
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_byte, in_end_of_text
// out      output     out_valid, out_stall, out_letter, out_has_letter,
//                     out_string_done, out_status
//
// Each byte passes through the input register and is decoded into a
// two-word result buffer, whose head slot shows its first word.
// One byte per cycle is taken while the buffer has room; a byte that folds
// to two letters holds the input while the buffer drains its second word.
// Reset is synchronous and active low and clears the sequence state and
// both registers' valid flags. A stalled output keeps its word and blocks
// the input once the buffer has no room.
module utf8_to_ascii_letter_folder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_letter,
  output logic       out_has_letter,
  output logic       out_string_done,
  output logic [1:0] out_status
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_eot_r;
  logic              room;
  logic              take;
  logic [1:0]        res_cnt;
  u2a_pkg::u2a_res_t res0;
  u2a_pkg::u2a_res_t res1;
  u2a_pkg::u2a_res_t head;

  assign take     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_eot_r  <= in_end_of_text;
    end
  end

  u2a_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_byte_r),
    .eot     (in_eot_r),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  u2a_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .room      (room)
  );

  assign out_letter      = head.letter;
  assign out_has_letter  = head.has_letter;
  assign out_string_done = head.string_done;
  assign out_status      = head.status;

  // A status shows only on the final word of a string.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_string_done |-> out_status == u2a_pkg::ST_OK)
    else $error("status on a word that does not end the string");

  // A word without a letter exists only to end a string.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_letter |-> out_string_done)
    else $error("empty word that does not end the string");

  // Every letter is lower case.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_letter |-> out_letter >= 7'h61 && out_letter <= 7'h7A)
    else $error("letter out of range");

  // A two-letter byte leaves the buffer full, so the next byte must wait.
  assert property (@(posedge clk) disable iff (!rst_n)
    take && res_cnt == 2'd2 |=> !room)
    else $error("buffer reports room while holding two words");

endmodule

// File: src/u2a_decode.sv
module u2a_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         byte_in,
  input  logic               eot,
  output logic [1:0]         res_cnt,
  output u2a_pkg::u2a_res_t  res0,
  output u2a_pkg::u2a_res_t  res1
);

  u2a_pkg::u2a_state_t st_r;
  u2a_pkg::u2a_state_t st_nxt;

  logic [1:0] n;
  logic [6:0] l0;
  logic [6:0] l1;
  logic [7:0] code;

  assign code = u2a_pkg::rom_lookup(st_r.lead_byte, byte_in);

  // Work out the letters and the next sequence state for this byte.
  always_comb begin
    st_nxt = st_r;
    n      = 2'd0;
    l0     = 7'd0;
    l1     = 7'd0;
    if (st_r.error_code == u2a_pkg::ST_OK) begin
      if (st_r.bytes_pending == 2'd0) begin
        if (byte_in[7] == 1'b0) begin
          if (byte_in >= 8'h41 && byte_in <= 8'h5A) begin
            l0 = byte_in[6:0] | 7'h20;
            n  = 2'd1;
          end else if (byte_in >= 8'h61 && byte_in <= 8'h7A) begin
            l0 = byte_in[6:0];
            n  = 2'd1;
          end
        end else if (byte_in[7:5] == 3'b110) begin
          st_nxt.bytes_pending = 2'd1;
          st_nxt.seq_length    = 3'd2;
          st_nxt.lead_byte     = byte_in;
        end else if (byte_in[7:4] == 4'b1110) begin
          st_nxt.bytes_pending = 2'd2;
          st_nxt.seq_length    = 3'd3;
          st_nxt.lead_byte     = byte_in;
        end else if (byte_in[7:3] == 5'b11110) begin
          st_nxt.bytes_pending = 2'd3;
          st_nxt.seq_length    = 3'd4;
          st_nxt.lead_byte     = byte_in;
        end else begin
          st_nxt.error_code = u2a_pkg::ST_INVALID;
        end
      end else begin
        st_nxt.bytes_pending = st_r.bytes_pending - 2'd1;
        if (st_nxt.bytes_pending == 2'd0) begin
          if (st_r.seq_length == 3'd2) begin
            case (code)
              u2a_pkg::RC_NONE:  st_nxt.error_code = u2a_pkg::ST_UNMAPPABLE;
              u2a_pkg::RC_EMPTY: n = 2'd0;
              u2a_pkg::RC_AE: begin
                l0 = 7'h61; l1 = 7'h65; n = 2'd2;
              end
              u2a_pkg::RC_TH: begin
                l0 = 7'h74; l1 = 7'h68; n = 2'd2;
              end
              u2a_pkg::RC_SS: begin
                l0 = 7'h73; l1 = 7'h73; n = 2'd2;
              end
              u2a_pkg::RC_OE: begin
                l0 = 7'h6F; l1 = 7'h65; n = 2'd2;
              end
              default: begin
                l0 = code[6:0];
                n  = 2'd1;
              end
            endcase
          end else begin
            st_nxt.error_code = u2a_pkg::ST_UNMAPPABLE;
          end
        end
      end
      // A string that ends inside a sequence is cut off.
      if (eot && st_nxt.bytes_pending != 2'd0 &&
          st_nxt.error_code == u2a_pkg::ST_OK) begin
        st_nxt.error_code = u2a_pkg::ST_INVALID;
      end
    end
  end

  // Shape the result words; the last one of a string carries the status.
  always_comb begin
    res0    = '{letter: l0, has_letter: 1'b1, string_done: 1'b0,
                status: u2a_pkg::ST_OK};
    res1    = '{letter: l1, has_letter: 1'b1, string_done: 1'b0,
                status: u2a_pkg::ST_OK};
    res_cnt = n;
    if (eot) begin
      if (n == 2'd0) begin
        res0    = '{letter: 7'd0, has_letter: 1'b0, string_done: 1'b1,
                    status: st_nxt.error_code};
        res_cnt = 2'd1;
      end else if (n == 2'd1) begin
        res0.string_done = 1'b1;
        res0.status      = st_nxt.error_code;
      end else begin
        res1.string_done = 1'b1;
        res1.status      = st_nxt.error_code;
      end
    end
  end

  // Sequence state advances on each byte taken; the final byte clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= eot ? '0 : st_nxt;
    end
  end

endmodule

// File: src/u2a_outbuf.sv
module u2a_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [1:0]         push_cnt,
  input  u2a_pkg::u2a_res_t  push0,
  input  u2a_pkg::u2a_res_t  push1,
  input  logic               out_stall,
  output logic               out_valid,
  output u2a_pkg::u2a_res_t  head,
  output logic               room
);

  u2a_pkg::u2a_res_t slot0_r;
  u2a_pkg::u2a_res_t slot1_r;
  logic [1:0]        cnt_r;
  logic              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = slot0_r;
  assign pop       = out_valid && !out_stall;

  // Space for two words once this cycle's word has left.
  assign room = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !out_stall);

  // Word count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push) begin
      cnt_r <= push_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Slots: a push always lands in an emptied buffer.
  always_ff @(posedge clk) begin
    if (push) begin
      slot0_r <= push0;
      slot1_r <= push1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule
